[rtl/assert_macros.svh]
// Assertion helpers for the flow tracker, clocked on aclk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its trigger
`define TFT_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Property holds in the cycle after its trigger
`define TFT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/tft_pkg.sv]
// ----------------------------------------------------------------------------
// tft_pkg
// Types, codes and reset values shared by the TCP flow tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tft_pkg;

    localparam int FLOW_ENTRIES_DEF = 32;
    localparam int SLOT_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 16;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_PAD_W = 6;

    // flow states
    localparam logic [1:0] ST_HALF = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RST  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // result kinds
    localparam logic EV_EVICT = 1'b0;
    localparam logic EV_PROC  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RST_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd4;

    localparam logic [CFG_W-1:0] HALF_TIMEOUT_RST   = 16'd60;
    localparam logic [CFG_W-1:0] FULL_TIMEOUT_RST   = 16'd300;
    localparam logic [CFG_W-1:0] RST_TIMEOUT_RST    = 16'd10;
    localparam logic [CFG_W-1:0] FIN_TIMEOUT_RST    = 16'd20;
    localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = 16'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_W1,
        S_W2,
        S_FLUSH
    } tft_state_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [1:0]  state;
        logic [31:0] time_sec;
    } tft_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        tft_entry_t        entry;
    } tft_wr_t;

    typedef struct packed {
        logic              event_kind;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       src_addr;
        logic [15:0]       src_port;
        logic [31:0]       dst_addr;
        logic [15:0]       dst_port;
        logic [1:0]        state;
        logic              created;
        logic              table_full;
    } tft_res_t;

endpackage

`default_nettype wire

[rtl/tft_table.sv]
// ----------------------------------------------------------------------------
// tft_table
// Flow table storage: one synchronous memory of entries with a registered
// read port, plus per-slot valid flops that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_table #(
    parameter int FLOW_ENTRIES = tft_pkg::FLOW_ENTRIES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [tft_pkg::SLOT_W-1:0]  rd_idx,
    output tft_pkg::tft_entry_t              rd_entry,
    output logic                             rd_valid,
    input  wire tft_pkg::tft_wr_t            wr,
    input  wire logic                        clr_en,
    input  wire logic [tft_pkg::SLOT_W-1:0]  clr_idx
);
    import tft_pkg::*;

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

    tft_entry_t             mem [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] valid_reg;
    tft_entry_t             rd_entry_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx[IDX_W-1:0]] <= wr.entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clr_en) begin
                valid_reg[clr_idx[IDX_W-1:0]] <= 1'b0;
            end
            if (wr.en) begin
                valid_reg[wr.idx[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx[IDX_W-1:0]];
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

[rtl/tcp_flow_table_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tcp_flow_table_tracker_unit
// Tracks TCP flows in a table, ages them out and reports each TCP packet.
// ----------------------------------------------------------------------------
// One packet descriptor is taken at a time. A TCP packet, or one that triggers
// an aging sweep, walks the whole flow table once, reading then checking each
// slot (S_RD, then S_CHK); the result side can stall the check. That single
// walk does the aging sweep, when one is due, and both forward and reverse
// lookups; then, for TCP packets, the write-back states S_W1 and S_W2 update
// the flow and its reverse. Non-TCP packets that trigger no sweep are taken in
// S_IDLE and give no result. Results are held one deep so the last beat can carry tlast.
`default_nettype none

module tcp_flow_table_tracker_unit #(
    parameter int FLOW_ENTRIES = tft_pkg::FLOW_ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // time_sec, src_addr, src_port, dst_addr, dst_port, tcp_flags
    input  wire logic [tft_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,   // has_tcp
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // slot, flow_src_addr, flow_src_port, flow_dst_addr, flow_dst_port,
    // flow_state, created, table_full, zero pad
    output logic [tft_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // event_kind
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tft_pkg::CFG_W-1:0]      cfg_data
);
    import tft_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FLOW_ENTRIES - 1);

    // configuration
    logic [CFG_W-1:0] half_to_reg, full_to_reg, rst_to_reg, fin_to_reg, chk_int_reg;
    logic [31:0]      last_sweep_reg;

    // packet under work
    logic [31:0] now_reg, sa_reg, da_reg;
    logic [15:0] sp_reg, dp_reg;
    logic [7:0]  flags_reg;
    logic        tcp_reg, sweep_reg;

    tft_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic              fwd_hit_reg, rev_hit_reg, free_hit_reg;
    logic [SLOT_W-1:0] fwd_slot_reg, rev_slot_reg, free_slot_reg;
    logic [1:0]        fwd_state_reg;
    logic [31:0]       rev_time_reg;

    // result holding and output stage
    logic     pend_valid_reg, m_valid_reg, m_last_reg;
    tft_res_t pend_reg, out_reg;

    // table port
    tft_entry_t rd_entry;
    logic       rd_valid, rd_en, clr_en;
    tft_wr_t    wr;

    tft_table #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr       (wr),
        .clr_en   (clr_en),
        .clr_idx  (idx_reg)
    );

    // input unpack
    logic [31:0] in_time, in_sa, in_da;
    logic [15:0] in_sp, in_dp;
    logic [32:0] sweep_diff;
    logic        sweep_now, s_accept;

    assign in_time  = s_tdata[31:0];
    assign in_sa    = s_tdata[63:32];
    assign in_sp    = s_tdata[79:64];
    assign in_da    = s_tdata[111:80];
    assign in_dp    = s_tdata[127:112];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sweep_diff = {1'b0, in_time} - {1'b0, last_sweep_reg};
    assign sweep_now  = (chk_int_reg != '0) && !sweep_diff[32] &&
                        (sweep_diff[31:0] >= {16'b0, chk_int_reg});

    // slot check
    logic [CFG_W-1:0] timeout;
    logic [32:0]      age;
    logic             expired, live, fwd_m, rev_m;

    always_comb begin
        unique case (rd_entry.state)
            ST_HALF: timeout = half_to_reg;
            ST_FULL: timeout = full_to_reg;
            ST_RST:  timeout = rst_to_reg;
            ST_FIN:  timeout = fin_to_reg;
            default: timeout = fin_to_reg;
        endcase
    end

    assign age     = {1'b0, now_reg} - {1'b0, rd_entry.time_sec};
    assign expired = sweep_reg && rd_valid && !age[32] && (age[31:0] >= {16'b0, timeout});
    assign live    = rd_valid && !expired;
    assign fwd_m   = live && rd_entry.src_addr == sa_reg && rd_entry.src_port == sp_reg &&
                     rd_entry.dst_addr == da_reg && rd_entry.dst_port == dp_reg;
    assign rev_m   = live && rd_entry.src_addr == da_reg && rd_entry.src_port == dp_reg &&
                     rd_entry.dst_addr == sa_reg && rd_entry.dst_port == sp_reg;

    // packet decisions
    logic       has_fl, ins, sym, rev_same;
    logic [1:0] st_fl, new_state;

    assign has_fl    = flags_reg[0] || flags_reg[2];
    assign st_fl     = flags_reg[2] ? ST_RST : ST_FIN;   // RST wins over FIN
    assign ins       = !fwd_hit_reg && free_hit_reg;
    assign sym       = (sa_reg == da_reg) && (sp_reg == dp_reg);
    assign rev_same  = fwd_hit_reg && (rev_slot_reg == fwd_slot_reg);
    assign new_state = has_fl ? st_fl :
                       fwd_hit_reg ? fwd_state_reg :
                       (rev_hit_reg || sym) ? ST_FULL : ST_HALF;

    logic can_push, chk_stall, w1_stall, fl_stall, last_idx;

    assign can_push  = !pend_valid_reg || !m_valid_reg || m_tready;
    assign chk_stall = expired && !can_push;
    assign w1_stall  = !can_push;
    assign fl_stall  = pend_valid_reg && m_valid_reg && !m_tready;
    assign last_idx  = (idx_reg == LAST_SLOT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_accept && (sweep_now || s_tuser)) state_next = S_RD;
            S_RD:    state_next = S_CHK;
            S_CHK: begin
                if (!chk_stall) begin
                    if (last_idx) state_next = tcp_reg ? S_W1 : S_FLUSH;
                    else          state_next = S_RD;
                end
            end
            S_W1:    if (!w1_stall) state_next = S_W2;
            S_W2:    state_next = S_FLUSH;
            S_FLUSH: if (!fl_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control strobes and datapath selects
    logic     push, flush;
    tft_res_t push_data;

    always_comb begin
        rd_en     = (state_reg == S_RD);
        clr_en    = (state_reg == S_CHK) && expired && !chk_stall;
        push      = 1'b0;
        flush     = (state_reg == S_FLUSH) && pend_valid_reg && !fl_stall;
        push_data = '0;
        wr        = '0;
        unique case (state_reg)
            S_CHK: begin
                push                 = clr_en;
                push_data.event_kind = EV_EVICT;
                push_data.slot       = idx_reg;
                push_data.src_addr   = rd_entry.src_addr;
                push_data.src_port   = rd_entry.src_port;
                push_data.dst_addr   = rd_entry.dst_addr;
                push_data.dst_port   = rd_entry.dst_port;
                push_data.state      = rd_entry.state;
            end
            S_W1: begin
                push                 = !w1_stall;
                push_data.event_kind = EV_PROC;
                push_data.src_addr   = sa_reg;
                push_data.src_port   = sp_reg;
                push_data.dst_addr   = da_reg;
                push_data.dst_port   = dp_reg;
                if (fwd_hit_reg || ins) begin
                    push_data.slot    = fwd_hit_reg ? fwd_slot_reg : free_slot_reg;
                    push_data.state   = new_state;
                    push_data.created = ins;
                end else begin
                    push_data.slot       = '0;
                    push_data.state      = ST_HALF;
                    push_data.table_full = 1'b1;
                end
                wr.en                = !w1_stall && (fwd_hit_reg || ins);
                wr.idx               = fwd_hit_reg ? fwd_slot_reg : free_slot_reg;
                wr.entry.src_addr    = sa_reg;
                wr.entry.src_port    = sp_reg;
                wr.entry.dst_addr    = da_reg;
                wr.entry.dst_port    = dp_reg;
                wr.entry.state       = new_state;
                wr.entry.time_sec    = now_reg;
            end
            S_W2: begin
                // reverse flow keeps its own time
                wr.en             = rev_hit_reg && (has_fl || ins) && !rev_same;
                wr.idx            = rev_slot_reg;
                wr.entry.src_addr = da_reg;
                wr.entry.src_port = dp_reg;
                wr.entry.dst_addr = sa_reg;
                wr.entry.dst_port = sp_reg;
                wr.entry.state    = has_fl ? st_fl : ST_FULL;
                wr.entry.time_sec = rev_time_reg;
            end
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg   <= in_time;
            sa_reg    <= in_sa;
            sp_reg    <= in_sp;
            da_reg    <= in_da;
            dp_reg    <= in_dp;
            flags_reg <= s_tdata[135:128];
        end
        if (state_reg == S_CHK && !chk_stall) begin
            if (fwd_m && !fwd_hit_reg) begin
                fwd_slot_reg  <= idx_reg;
                fwd_state_reg <= rd_entry.state;
            end
            if (rev_m && !rev_hit_reg) begin
                rev_slot_reg <= idx_reg;
                rev_time_reg <= rd_entry.time_sec;
            end
            if (!live && !free_hit_reg) begin
                free_slot_reg <= idx_reg;
            end
        end
        if (push) begin
            pend_reg <= push_data;
        end
        if (push && pend_valid_reg) begin
            out_reg    <= pend_reg;
            m_last_reg <= 1'b0;
        end else if (flush) begin
            out_reg    <= pend_reg;
            m_last_reg <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            half_to_reg    <= HALF_TIMEOUT_RST;
            full_to_reg    <= FULL_TIMEOUT_RST;
            rst_to_reg     <= RST_TIMEOUT_RST;
            fin_to_reg     <= FIN_TIMEOUT_RST;
            chk_int_reg    <= CHECK_INTERVAL_RST;
            last_sweep_reg <= '0;
            tcp_reg        <= 1'b0;
            sweep_reg      <= 1'b0;
            idx_reg        <= '0;
            fwd_hit_reg    <= 1'b0;
            rev_hit_reg    <= 1'b0;
            free_hit_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_HALF_TIMEOUT:   half_to_reg <= cfg_data;
                    REG_FULL_TIMEOUT:   full_to_reg <= cfg_data;
                    REG_RST_TIMEOUT:    rst_to_reg  <= cfg_data;
                    REG_FIN_TIMEOUT:    fin_to_reg  <= cfg_data;
                    REG_CHECK_INTERVAL: chk_int_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_accept) begin
                tcp_reg      <= s_tuser;
                sweep_reg    <= sweep_now;
                idx_reg      <= '0;
                fwd_hit_reg  <= 1'b0;
                rev_hit_reg  <= 1'b0;
                free_hit_reg <= 1'b0;
                if (sweep_now) last_sweep_reg <= in_time;
            end
            if (state_reg == S_CHK && !chk_stall) begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (fwd_m) fwd_hit_reg <= 1'b1;
                if (rev_m) rev_hit_reg <= 1'b1;
                if (!live) free_hit_reg <= 1'b1;
            end
            if (push) begin
                pend_valid_reg <= 1'b1;
            end else if (flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((push && pend_valid_reg) || flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.table_full, out_reg.created, out_reg.state,
                       out_reg.dst_port, out_reg.dst_addr, out_reg.src_port, out_reg.src_addr,
                       out_reg.slot};

    `include "assert_macros.svh"

    `TFT_ASSERT_NOW(a_idle_no_pend, s_tready, !pend_valid_reg, "result held while idle")
    `TFT_ASSERT_NOW(a_wr_phase, wr.en, state_reg == S_W1 || state_reg == S_W2, "stray table write")
    `TFT_ASSERT_NEXT(a_flush_last, flush, m_tvalid && m_tlast, "flush without last beat")

endmodule

`default_nettype wire
